// ----- rtl/rycc_pkg.sv -----
// rycc_pkg: types, fixed-point widths and coefficient tables for the colour converter
// no dependencies; imported by rycc_dot and rgb_ycbcr_color_converter
package rycc_pkg;

  localparam int COEF_FRAC_BITS = 16;
  // sign plus two integer bits covers the largest weight (about 2.11)
  localparam int COEF_W = COEF_FRAC_BITS + 3;
  // operands range -128..255 after the offset removal
  localparam int X_W    = 9;
  localparam int PROD_W = COEF_W + X_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int T_W    = ACC_W - COEF_FRAC_BITS;

  localparam logic REQ_FWD  = 1'b0;
  localparam logic REQ_INV  = 1'b1;
  localparam logic MODE_709 = 1'b0;
  localparam logic MODE_601 = 1'b1;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [X_W-1:0]    x_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [T_W-1:0]    t_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] chan_one;
    logic [7:0] chan_two;
    logic [7:0] chan_three;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] res_one;
    logic [7:0] res_two;
    logic [7:0] res_three;
  } pix_out_t;

  localparam longint ONE2 = longint'(1) << (COEF_FRAC_BITS + 1);

  // half rounded away from zero on the exact ratio n/d
  localparam longint F709_YR  = (2126*219 * ONE2 + 10000*255) / (2 * 10000*255);
  localparam longint F709_YG  = (7152*219 * ONE2 + 10000*255) / (2 * 10000*255);
  localparam longint F709_YB  = (722*219  * ONE2 + 10000*255) / (2 * 10000*255);
  localparam longint F709_CBR = (2126*224 * ONE2 + 18556*255) / (2 * 18556*255);
  localparam longint F709_CBG = (7152*224 * ONE2 + 18556*255) / (2 * 18556*255);
  localparam longint F_HALF   = (5*224    * ONE2 + 10*255)    / (2 * 10*255);
  localparam longint F709_CRG = (7152*224 * ONE2 + 15748*255) / (2 * 15748*255);
  localparam longint F709_CRB = (722*224  * ONE2 + 15748*255) / (2 * 15748*255);

  localparam longint F601_YR  = (299*219 * ONE2 + 1000*255) / (2 * 1000*255);
  localparam longint F601_YG  = (587*219 * ONE2 + 1000*255) / (2 * 1000*255);
  localparam longint F601_YB  = (114*219 * ONE2 + 1000*255) / (2 * 1000*255);
  localparam longint F601_CBR = (longint'(168736)*224 * ONE2 + longint'(1000000)*255)
                                / (2 * longint'(1000000)*255);
  localparam longint F601_CBG = (longint'(331264)*224 * ONE2 + longint'(1000000)*255)
                                / (2 * longint'(1000000)*255);
  localparam longint F601_CRG = (longint'(418688)*224 * ONE2 + longint'(1000000)*255)
                                / (2 * longint'(1000000)*255);
  localparam longint F601_CRB = (longint'(81312)*224 * ONE2 + longint'(1000000)*255)
                                / (2 * longint'(1000000)*255);

  localparam longint I_Y      = (longint'(1164383562) * ONE2 + longint'(1000000000))
                                / (2 * longint'(1000000000));
  localparam longint I709_RCR = (longint'(1792741071) * ONE2 + longint'(1000000000))
                                / (2 * longint'(1000000000));
  localparam longint I709_GCB = (longint'(2132486143) * ONE2 + 64'sd10000000000)
                                / (2 * 64'sd10000000000);
  localparam longint I709_GCR = (64'sd5329093286 * ONE2 + 64'sd10000000000)
                                / (2 * 64'sd10000000000);
  localparam longint I709_BCB = (longint'(2112401786) * ONE2 + longint'(1000000000))
                                / (2 * longint'(1000000000));
  localparam longint I601_RCR = (longint'(1596026317) * ONE2 + longint'(1000000000))
                                / (2 * longint'(1000000000));
  localparam longint I601_GCB = (64'sd3917615979 * ONE2 + 64'sd10000000000)
                                / (2 * 64'sd10000000000);
  localparam longint I601_GCR = (64'sd8129674985 * ONE2 + 64'sd10000000000)
                                / (2 * 64'sd10000000000);
  localparam longint I601_BCB = (longint'(2017232218) * ONE2 + longint'(1000000000))
                                / (2 * longint'(1000000000));

  // [mode][output channel][input channel], mode 0 is BT.709
  localparam longint FWD_K [2][3][3] = '{
    '{ '{ F709_YR,  F709_YG,  F709_YB  },
       '{ -F709_CBR, -F709_CBG, F_HALF  },
       '{ F_HALF,   -F709_CRG, -F709_CRB } },
    '{ '{ F601_YR,  F601_YG,  F601_YB  },
       '{ -F601_CBR, -F601_CBG, F_HALF  },
       '{ F_HALF,   -F601_CRG, -F601_CRB } }
  };

  localparam longint INV_K [2][3][3] = '{
    '{ '{ I_Y, 0,          I709_RCR  },
       '{ I_Y, -I709_GCB,  -I709_GCR },
       '{ I_Y, I709_BCB,   0         } },
    '{ '{ I_Y, 0,          I601_RCR  },
       '{ I_Y, -I601_GCB,  -I601_GCR },
       '{ I_Y, I601_BCB,   0         } }
  };

  function automatic coef_t coef_lookup(logic mode, logic req, logic [1:0] row,
                                        logic [1:0] col);
    longint k;
    if (req == REQ_INV) begin
      k = INV_K[mode][row][col];
    end else begin
      k = FWD_K[mode][row][col];
    end
    return coef_t'(k);
  endfunction

endpackage

// ----- rtl/rycc_dot.sv -----
// rycc_dot: two-stage three-term dot product with the rounding half added
// depends on rycc_pkg
module rycc_dot import rycc_pkg::*; (
  input  logic  clk,
  input  coef_t k [3],
  input  x_t    x [3],
  output acc_t  acc
);

  localparam acc_t HALF = acc_t'(longint'(1) << (COEF_FRAC_BITS - 1));

  prod_t prod [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod[i] <= prod_t'(k[i] * x[i]);
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_t'(prod[0]) + acc_t'(prod[1]) + acc_t'(prod[2]) + HALF;
  end

endmodule

// ----- rtl/rgb_ycbcr_color_converter.sv -----
// rgb_ycbcr_color_converter: top level, RGB to studio YCbCr and back, BT.601 or BT.709
// depends on rycc_pkg and rycc_dot
// done and result are registered together, after the s1, product and sum stages
// throughput: one pixel per clock, busy is always low; four register stages in line
// mode is sampled with the pixel at the start transfer
// reset (synchronous) empties the pipeline and selects BT.601
module rgb_ycbcr_color_converter import rycc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_en,
  input  logic     wr_data,
  input  logic     start,
  output logic     busy,
  input  pix_in_t  pixel,
  output logic     done,
  output pix_out_t result
);

  localparam acc_t ROUND_BIAS = acc_t'((longint'(1) << COEF_FRAC_BITS) - 1);

  logic bt601_mode;
  logic s1_valid, s2_valid, s3_valid;
  logic s1_type, s2_type, s3_type, out_type;
  logic s1_mode;
  x_t   s1_x [3];
  coef_t k [3][3];
  acc_t  acc [3];
  logic [7:0] res_next [3];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bt601_mode <= MODE_601;
    end else if (wr_en) begin
      bt601_mode <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      done     <= s3_valid;
    end
  end

  // offsets removed here so the multipliers see signed operands
  always_ff @(posedge clk) begin
    s1_type <= pixel.req_type;
    s1_mode <= bt601_mode;
    s2_type <= s1_type;
    s3_type <= s2_type;
    out_type <= s3_type;
    if (pixel.req_type == REQ_INV) begin
      s1_x[0] <= x_t'({1'b0, pixel.chan_one}) - x_t'(16);
      s1_x[1] <= x_t'({1'b0, pixel.chan_two}) - x_t'(128);
      s1_x[2] <= x_t'({1'b0, pixel.chan_three}) - x_t'(128);
    end else begin
      s1_x[0] <= x_t'({1'b0, pixel.chan_one});
      s1_x[1] <= x_t'({1'b0, pixel.chan_two});
      s1_x[2] <= x_t'({1'b0, pixel.chan_three});
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        k[r][c] = coef_lookup(s1_mode, s1_type, 2'(r), 2'(c));
      end
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    rycc_dot u_dot (
      .clk (clk),
      .k   (k[ch]),
      .x   (s1_x),
      .acc (acc[ch])
    );

    acc_t acc_adj;
    t_t   t;
    logic signed [T_W:0] v, lo, hi;

    // truncation toward zero on the shifted sum, then offset and clamp
    always_comb begin
      acc_adj = acc[ch] + (acc[ch][ACC_W-1] ? ROUND_BIAS : acc_t'(0));
      t       = acc_adj[ACC_W-1:COEF_FRAC_BITS];
      if (s3_type == REQ_INV) begin
        lo = (T_W+1)'(0);
        hi = (T_W+1)'(255);
        v  = (T_W+1)'(t);
      end else if (ch == 0) begin
        lo = (T_W+1)'(16);
        hi = (T_W+1)'(235);
        v  = (T_W+1)'(t) + (T_W+1)'(16);
      end else begin
        lo = (T_W+1)'(16);
        hi = (T_W+1)'(240);
        v  = (T_W+1)'(t) + (T_W+1)'(128);
      end
      priority if (v < lo) begin
        res_next[ch] = lo[7:0];
      end else if (v > hi) begin
        res_next[ch] = hi[7:0];
      end else begin
        res_next[ch] = v[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    result.res_one   <= res_next[0];
    result.res_two   <= res_next[1];
    result.res_three <= res_next[2];
  end

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("start transfer did not produce a result");

  a_done_has_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 4))
    else $error("result without a start transfer");

  a_fwd_range: assert property (@(posedge clk) disable iff (rst)
    (done && out_type == REQ_FWD) |->
      (result.res_one >= 8'd16 && result.res_one <= 8'd235 &&
       result.res_two >= 8'd16 && result.res_two <= 8'd240 &&
       result.res_three >= 8'd16 && result.res_three <= 8'd240))
    else $error("forward result outside studio range");

endmodule
